// ===== hw/rtl/rmf_pkg.sv =====
package rmf_pkg;

  localparam int MAX_RADIUS  = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SIDE_MAX    = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = SIDE_MAX * MAX_WIDTH;
  localparam int WIN_MAX     = SIDE_MAX * SIDE_MAX;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WIN_W       = $clog2(WIN_MAX + 1);

  // register indexes on the config port
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
  } rank_ctl_t;

endpackage

// ===== hw/rtl/rgb_median_filter_window.sv =====
// Sequence: an input beat that causes no result is taken at once. A beat that
//   causes a result runs the setup, window walk, flush, median search and hold steps.
// Throughput: one item at a time; set by the line-store read port, one window
//   pixel per cycle, plus the 8-bit median search.
// Reset: counts clear, radius 1, width 640, height 480; line store is not
//   cleared (entries are only read after being written).
module rgb_median_filter_window import rmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        frame_end
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_GATHER, ST_FLUSH, ST_RANK, ST_HOLD
  } state_t;

  state_t state;

  // config registers
  logic [1:0]  radius;
  logic [10:0] width_cfg;
  logic [10:0] height_cfg;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS: prdata = {30'b0, radius};
      REG_WIDTH:  prdata = {21'b0, width_cfg};
      REG_HEIGHT: prdata = {21'b0, height_cfg};
      default:    prdata = '0;
    endcase
  end

  // effective (clamped) geometry
  logic [1:0]       eff_r;
  logic [10:0]      eff_w, eff_h;
  logic [21:0]      total_full;
  logic [CNT_W-1:0] total, lag;
  logic [12:0]      r_times_w;

  assign eff_r = (32'(radius) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius;
  assign eff_w = (width_cfg == '0) ? 11'd1 :
                 (32'(width_cfg) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_cfg;
  assign eff_h = (height_cfg == '0) ? 11'd1 :
                 (32'(height_cfg) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : height_cfg;
  assign total_full = eff_w * eff_h;
  assign total      = total_full[CNT_W-1:0];
  assign r_times_w  = eff_r * eff_w;
  assign lag        = CNT_W'(r_times_w) + CNT_W'(eff_r);

  // frame position tracking
  logic [CNT_W-1:0]  in_cnt, out_cnt;
  logic [ADDR_W-1:0] wr_addr, out_addr;
  logic [9:0]        out_x, out_y;
  logic [CNT_W-1:0]  in_cnt_inc;

  assign in_cnt_inc = in_cnt + 1'b1;

  // line store: pixel p at address p mod depth
  pixel_t            store [STORE_DEPTH];
  pixel_t            rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= {red_in, green_in, blue_in};
    end
    rdata <= store[rd_addr];
  end

  // window walk
  logic signed [3:0] dy, dx;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W:0]   setup_sum;
  logic [ADDR_W:0]   row_sum;
  logic signed [ADDR_W+1:0] col_sum;
  logic signed [11:0] xx, yy;
  logic              in_win;
  logic              take_q;
  logic signed [3:0] r_s;

  assign r_s = $signed({2'b0, eff_r});

  assign setup_sum = (ADDR_W+1)'(out_addr) + (ADDR_W+1)'(STORE_DEPTH)
                   - (ADDR_W+1)'(r_times_w);
  assign row_sum   = (ADDR_W+1)'(row_base) + (ADDR_W+1)'(eff_w);
  assign col_sum   = $signed({2'b0, row_base}) + (ADDR_W+2)'(dx);

  always_comb begin
    if (col_sum < 0) begin
      rd_addr = ADDR_W'(col_sum + (ADDR_W+2)'(STORE_DEPTH));
    end else if (col_sum >= (ADDR_W+2)'(STORE_DEPTH)) begin
      rd_addr = ADDR_W'(col_sum - (ADDR_W+2)'(STORE_DEPTH));
    end else begin
      rd_addr = ADDR_W'(col_sum);
    end
  end

  assign xx = $signed({2'b0, out_x}) + 12'(dx);
  assign yy = $signed({2'b0, out_y}) + 12'(dy);
  assign in_win = (xx >= 0) && (xx < $signed({1'b0, eff_w})) &&
                  (yy >= 0) && (yy < $signed({1'b0, eff_h}));

  // ranking unit
  rank_ctl_t  rctl;
  logic       rdone;
  logic [7:0] med_r, med_g, med_b;

  assign rctl.clear = (state == ST_SETUP);
  assign rctl.load  = take_q;
  assign rctl.start = (state == ST_FLUSH);

  rmf_rank u_rank (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rctl),
    .pix   (rdata),
    .done  (rdone),
    .med_r (med_r),
    .med_g (med_g),
    .med_b (med_b)
  );

  logic accept, out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign wr_en    = accept && !command && (in_cnt < total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      radius     <= 2'd1;
      width_cfg  <= 11'd640;
      height_cfg <= 11'd480;
      in_cnt     <= '0;
      out_cnt    <= '0;
      wr_addr    <= '0;
      out_addr   <= '0;
      out_x      <= '0;
      out_y      <= '0;
      out_valid  <= 1'b0;
      take_q     <= 1'b0;
    end else begin
      take_q <= 1'b0;
      // the hold step reloads the output register itself
      if (out_valid && !out_stall && state != ST_HOLD) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr && paddr[3:2] != 2'd3) begin
        unique case (paddr[3:2])
          REG_RADIUS: radius     <= pwdata[1:0];
          REG_WIDTH:  width_cfg  <= pwdata[10:0];
          REG_HEIGHT: height_cfg <= pwdata[10:0];
          default: ;
        endcase
        in_cnt   <= '0;
        out_cnt  <= '0;
        wr_addr  <= '0;
        out_addr <= '0;
        out_x    <= '0;
        out_y    <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (command) begin
              // drain tick: only once the whole frame is in
              if (in_cnt >= total && out_cnt < total) state <= ST_SETUP;
            end else if (in_cnt < total) begin
              in_cnt  <= in_cnt_inc;
              wr_addr <= (wr_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_addr + 1'b1;
              if (in_cnt_inc - out_cnt > lag) state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          row_base <= (setup_sum >= (ADDR_W+1)'(STORE_DEPTH)) ?
                      ADDR_W'(setup_sum - (ADDR_W+1)'(STORE_DEPTH)) : ADDR_W'(setup_sum);
          dy    <= -r_s;
          dx    <= -r_s;
          state <= ST_GATHER;
        end
        ST_GATHER: begin
          take_q <= in_win;
          if (dx == r_s) begin
            dx <= -r_s;
            dy <= dy + 1'b1;
            row_base <= (row_sum >= (ADDR_W+1)'(STORE_DEPTH)) ?
                        ADDR_W'(row_sum - (ADDR_W+1)'(STORE_DEPTH)) : ADDR_W'(row_sum);
            if (dy == r_s) state <= ST_FLUSH;
          end else begin
            dx <= dx + 1'b1;
          end
        end
        ST_FLUSH: state <= ST_RANK;
        ST_RANK: begin
          if (rdone) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            red_out   <= med_r;
            green_out <= med_g;
            blue_out  <= med_b;
            frame_end <= (out_cnt + 1'b1 == total);
            if (out_cnt + 1'b1 >= total) begin
              // frame wrap
              out_cnt  <= '0;
              in_cnt   <= '0;
              wr_addr  <= '0;
              out_addr <= '0;
              out_x    <= '0;
              out_y    <= '0;
            end else begin
              out_cnt  <= out_cnt + 1'b1;
              out_addr <= (out_addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : out_addr + 1'b1;
              if (11'(out_x) + 11'd1 == eff_w) begin
                out_x <= '0;
                out_y <= out_y + 1'b1;
              end else begin
                out_x <= out_x + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // no result is ever produced ahead of its pixels
  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    out_cnt <= in_cnt)
    else $error("output count ran ahead of input count");

  // store data is only captured for reads issued during the window walk
  a_take_from_walk: assert property (@(posedge clk) disable iff (rst)
    take_q |-> $past(state == ST_GATHER))
    else $error("window load without a walk read");

  // the median unit only finishes while the sequencer waits for it
  a_done_in_rank: assert property (@(posedge clk) disable iff (rst)
    rdone |-> state == ST_RANK)
    else $error("median done outside rank phase");

  // a new result only comes from the hold step
  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_HOLD))
    else $error("result loaded outside hold");

endmodule

// ===== hw/rtl/rmf_rank.sv =====
// Window buffer plus bitwise median search, one bit at a time from the top, each in a compare and an update step.
module rmf_rank import rmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rank_ctl_t  ctl,
  input  pixel_t     pix,
  output logic       done,
  output logic [7:0] med_r,
  output logic [7:0] med_g,
  output logic [7:0] med_b
);

  pixel_t             win [WIN_MAX];
  logic [WIN_W-1:0]   num;
  logic               running;
  logic               phase;
  logic [2:0]         bitpos;
  logic [WIN_MAX-1:0] lt_r, lt_g, lt_b;
  logic [7:0]         t_r, t_g, t_b;
  logic [WIN_W-1:0]   cnt_r, cnt_g, cnt_b;
  logic [WIN_W-1:0]   half;

  assign t_r  = med_r | (8'd1 << bitpos);
  assign t_g  = med_g | (8'd1 << bitpos);
  assign t_b  = med_b | (8'd1 << bitpos);
  assign half = num >> 1;

  always_comb begin
    cnt_r = '0;
    cnt_g = '0;
    cnt_b = '0;
    for (int i = 0; i < WIN_MAX; i++) begin
      cnt_r = cnt_r + WIN_W'(lt_r[i]);
      cnt_g = cnt_g + WIN_W'(lt_g[i]);
      cnt_b = cnt_b + WIN_W'(lt_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      win[num[WIN_W-1:0]] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num     <= '0;
      running <= 1'b0;
      phase   <= 1'b0;
      bitpos  <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.clear) begin
        num <= '0;
      end else if (ctl.load) begin
        num <= num + 1'b1;
      end
      if (ctl.start) begin
        running <= 1'b1;
        phase   <= 1'b0;
        bitpos  <= 3'd7;
        med_r   <= '0;
        med_g   <= '0;
        med_b   <= '0;
      end else if (running) begin
        phase <= ~phase;
        if (!phase) begin
          for (int i = 0; i < WIN_MAX; i++) begin
            lt_r[i] <= (num > WIN_W'(i)) && (win[i][23:16] < t_r);
            lt_g[i] <= (num > WIN_W'(i)) && (win[i][15:8] < t_g);
            lt_b[i] <= (num > WIN_W'(i)) && (win[i][7:0] < t_b);
          end
        end else begin
          if (cnt_r <= half) med_r <= t_r;
          if (cnt_g <= half) med_g <= t_g;
          if (cnt_b <= half) med_b <= t_b;
          if (bitpos == 3'd0) begin
            running <= 1'b0;
            done    <= 1'b1;
          end else begin
            bitpos <= bitpos - 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_rgb_median_filter_window.sv =====
`timescale 1ns / 1ps

// Scoreboard: mirrors the filter's frame state and keeps the queue of expected medians.
class median_scoreboard;
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } median_t;

  logic [23:0] frame_mem [rmf_pkg::STORE_DEPTH];
  int unsigned pix_cnt, res_cnt;
  logic [1:0]  radius_reg;
  logic [10:0] width_reg, height_reg;
  median_t     pending[$];
  int          errors;

  function void reset();
    pix_cnt = 0; res_cnt = 0;
    radius_reg = 2'd1; width_reg = 11'd640; height_reg = 11'd480;
    pending.delete(); errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    if (idx == rmf_pkg::REG_RADIUS) radius_reg = val[1:0];
    else if (idx == rmf_pkg::REG_WIDTH) width_reg = val[10:0];
    else if (idx == rmf_pkg::REG_HEIGHT) height_reg = val[10:0];
    else return;
    pix_cnt = 0; res_cnt = 0;
  endfunction

  function int unsigned rad();
    return (radius_reg > rmf_pkg::MAX_RADIUS) ? rmf_pkg::MAX_RADIUS : radius_reg;
  endfunction
  function int unsigned wid();
    if (width_reg == 0) return 1;
    return (width_reg > rmf_pkg::MAX_WIDTH) ? rmf_pkg::MAX_WIDTH : width_reg;
  endfunction
  function int unsigned hgt();
    if (height_reg == 0) return 1;
    return (height_reg > rmf_pkg::MAX_HEIGHT) ? rmf_pkg::MAX_HEIGHT : height_reg;
  endfunction

  function logic [7:0] rank_mid(logic [7:0] v[$]);
    v.sort();
    return v[v.size() / 2];
  endfunction

  function void queue_median();
    int unsigned r, w, h;
    int y, x, yy, xx;
    logic [23:0] e;
    logic [7:0] rv[$], gv[$], bv[$];
    median_t m;
    r = rad(); w = wid(); h = hgt();
    y = res_cnt / w; x = res_cnt % w;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      yy = y + dy;
      if (yy < 0 || yy >= int'(h)) continue;
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        xx = x + dx;
        if (xx < 0 || xx >= int'(w)) continue;
        e = frame_mem[(yy * w + xx) % rmf_pkg::STORE_DEPTH];
        rv.push_back(e[23:16]); gv.push_back(e[15:8]); bv.push_back(e[7:0]);
      end
    end
    m.red = rank_mid(rv); m.green = rank_mid(gv); m.blue = rank_mid(bv);
    m.last = (res_cnt + 1 == w * h);
    pending.push_back(m);
    res_cnt++;
    if (res_cnt >= w * h) begin
      res_cnt = 0; pix_cnt = 0;
    end
  endfunction

  // Note one accepted input beat.
  function void note_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned total, lag;
    total = wid() * hgt();
    lag = rad() * wid() + rad();
    if (cmd) begin
      if (pix_cnt >= total && res_cnt < total) queue_median();
      return;
    end
    if (pix_cnt >= total) return;
    frame_mem[pix_cnt % rmf_pkg::STORE_DEPTH] = {r, g, b};
    pix_cnt++;
    if (pix_cnt - res_cnt > lag) queue_median();
  endfunction

  // Check one accepted result beat.
  function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
    median_t m;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result r=%0d g=%0d b=%0d fe=%0d", $time, r, g, b, fe);
      errors++;
      return;
    end
    m = pending.pop_front();
    if (r !== m.red) begin
      $display("%0t: red expected %0d actual %0d", $time, m.red, r); errors++;
    end
    if (g !== m.green) begin
      $display("%0t: green expected %0d actual %0d", $time, m.green, g); errors++;
    end
    if (b !== m.blue) begin
      $display("%0t: blue expected %0d actual %0d", $time, m.blue, b); errors++;
    end
    if (fe !== m.last) begin
      $display("%0t: frame_end expected %0d actual %0d", $time, m.last, fe); errors++;
    end
  endfunction
endclass

module tb_rgb_median_filter_window;
  import rmf_pkg::*;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall, command;
  logic [7:0]  red_in, green_in, blue_in;
  logic        out_valid, out_stall;
  logic [7:0]  red_out, green_out, blue_out;
  logic        frame_end;

  median_scoreboard sb;
  // receiver hold-off request from the stimulus process
  bit          hold_sink;
  bit          sink_busy;

  rgb_median_filter_window dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check every accepted beat, stall at random, plus a long hold-off.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_result(red_out, green_out, blue_out, frame_end);
      if (hold_sink && !sink_busy) begin
        sink_busy = 1;
        out_stall <= 1'b1;
        gap = 400;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        sink_busy = 0;
        // random stall gap per beat; a third of the time no gap is drawn at all
        if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
        else begin
          gap = $urandom_range(0, 7);
          out_stall <= (gap != 0);
        end
      end
    end
  end

  // Config write: setup then access beat, then psel and penable drop; only used while idle.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one beat after a random gap, none with no_gap, hold until taken.
  task automatic send_beat(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; command <= cmd;
    red_in <= r; green_in <= g; blue_in <= b;
    do @(posedge clk); while (in_stall);
    sb.note_beat(cmd, r, g, b);
  endtask

  task automatic send_pixel();
    send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Wait until all medians are out, then the worst-case latency more.
  task automatic drain_wait();
    int lim;
    in_valid <= 1'b0;
    lim = 0;
    while (sb.pending.size() != 0 && lim < 200000) begin
      @(posedge clk); lim++;
    end
    repeat (80) @(posedge clk);
  endtask

  // Whole frame, then drain ticks until the scoreboard expects the last median.
  task automatic run_frame(int unsigned n);
    for (int i = 0; i < n; i++) send_pixel();
    while (sb.pix_cnt != 0) send_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned w, h, total;
    sb = new();
    sb.reset();
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; command = 0; red_in = 0; green_in = 0; blue_in = 0;
    hold_sink = 0; sink_busy = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny frames, extremes of radius and sizes.
    cfg_write(REG_RADIUS, 32'd0);
    cfg_write(REG_WIDTH, 32'd1);
    cfg_write(REG_HEIGHT, 32'd1);
    // early drain on an empty frame: nothing comes out
    send_beat(1'b1, 8'hff, 8'hff, 8'hff);
    send_beat(1'b0, 8'h00, 8'hff, 8'h80);
    // frame complete at R=0: next pixel starts a fresh frame
    send_beat(1'b0, 8'hff, 8'h00, 8'h7f);
    drain_wait();
    cfg_write(REG_RADIUS, 32'd3);
    cfg_write(REG_WIDTH, 32'd3);
    cfg_write(REG_HEIGHT, 32'd3);
    send_beat(1'b0, 8'hff, 8'hff, 8'hff);
    send_beat(1'b1, 8'h00, 8'h00, 8'h00);   // early drain
    for (int i = 0; i < 8; i++) send_pixel();
    send_pixel();                            // pixel after a full frame is dropped
    send_beat(1'b1, 8'h00, 8'h00, 8'h00);
    drain_wait();
    // Out of range values: width and height 0, width above max, reserved index.
    cfg_write(REG_WIDTH, 32'd0);
    cfg_write(REG_HEIGHT, 32'd0);
    cfg_write(2'd3, 32'hffff_ffff);
    run_frame(1);
    drain_wait();
    cfg_write(REG_WIDTH, 32'h7ff);
    cfg_write(REG_HEIGHT, 32'd1);
    cfg_write(REG_RADIUS, 32'd2);
    // abort a partial frame with a config write
    for (int i = 0; i < 3; i++) send_pixel();
    drain_wait();
    cfg_write(REG_WIDTH, 32'd4);
    cfg_write(REG_HEIGHT, 32'd2);
    run_frame(8);
    drain_wait();

    // Random frames: mostly small, mostly well-formed, some noise.
    total = 0;
    while (total < 1400) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      cfg_write(REG_RADIUS, $urandom_range(0, 3));
      cfg_write(REG_WIDTH, w);
      cfg_write(REG_HEIGHT, h);
      for (int i = 0; i < w * h; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        send_pixel();
      end
      // extra pixel only while results are still pending, so it is dropped
      if (sb.pix_cnt != 0 && $urandom_range(0, 7) == 0) send_pixel();
      while (sb.pix_cnt != 0) send_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      total += w * h;
      drain_wait();
    end

    // Back-pressure: receiver holds off while input keeps coming.
    cfg_write(REG_RADIUS, 32'd0);
    cfg_write(REG_WIDTH, 32'd16);
    cfg_write(REG_HEIGHT, 32'd4);
    hold_sink = 1;
    wait (sink_busy);
    hold_sink = 0;
    for (int i = 0; i < 64; i++)
      send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 1);
    drain_wait();

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never came", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_rank.sv
hw/rtl/rgb_median_filter_window.sv
test/tb_rgb_median_filter_window.sv
